// ===== rtl/core/pce_pkg.sv =====
// Shared constants and types of the Playfair encryptor.
`default_nettype none

package pce_pkg;

	localparam int unsigned LETTERS = 26;
	localparam int unsigned CELLS   = 25;
	localparam int unsigned SIDE    = 5;
	localparam int unsigned LET_W   = 5;
	localparam int unsigned CELL_W  = 5;

	localparam logic [LET_W-1:0] IDX_I     = LET_W'(8);
	localparam logic [LET_W-1:0] IDX_J     = LET_W'(9);
	localparam logic [LET_W-1:0] IDX_X     = LET_W'(23);
	localparam logic [LET_W-1:0] NO_LETTER = LET_W'(LETTERS);
	localparam logic [6:0]       ASCII_A   = 7'h41;

	typedef enum logic [1:0] {
		OP_KEY_BYTE  = 2'd0,
		OP_KEY_END   = 2'd1,
		OP_TEXT_BYTE = 2'd2,
		OP_TEXT_END  = 2'd3
	} opcode_t;

	// One placement into the key square: both directions are written together.
	typedef struct packed {
		logic              we;
		logic [CELL_W-1:0] slot;
		logic [LET_W-1:0]  letter;
	} tbl_wr_t;

	typedef struct packed {
		logic              cof_re;
		logic [LET_W-1:0]  cof_addr_a;
		logic [LET_W-1:0]  cof_addr_b;
		logic              lac_re;
		logic [CELL_W-1:0] lac_addr_a;
		logic [CELL_W-1:0] lac_addr_b;
	} tbl_rd_t;

	typedef struct packed {
		logic [CELL_W-1:0] cell_a;
		logic [CELL_W-1:0] cell_b;
		logic [LET_W-1:0]  letter_a;
		logic [LET_W-1:0]  letter_b;
	} tbl_rdata_t;

	typedef struct packed {
		logic [LET_W-1:0] lead;
		logic [LET_W-1:0] trail;
	} pair_t;

endpackage

`default_nettype wire

// ===== rtl/core/pce_table.sv =====
// Key square memories: letter of each cell and cell of each letter.
`default_nettype none

module pce_table (
	input  wire logic               clk,
	input  wire pce_pkg::tbl_wr_t   wr,
	input  wire pce_pkg::tbl_rd_t   rd,
	output pce_pkg::tbl_rdata_t     rdata
);

	logic [pce_pkg::LET_W-1:0]  lac_mem [0:pce_pkg::CELLS-1];
	logic [pce_pkg::CELL_W-1:0] cof_mem [0:pce_pkg::LETTERS-1];

	always_ff @(posedge clk) begin
		if (wr.we) begin
			lac_mem[wr.slot]   <= wr.letter;
			cof_mem[wr.letter] <= wr.slot;
		end
	end

	// Read data holds until the next enabled read, so a stalled lookup keeps its result.
	always_ff @(posedge clk) begin
		if (rd.cof_re) begin
			rdata.cell_a <= cof_mem[rd.cof_addr_a];
			rdata.cell_b <= cof_mem[rd.cof_addr_b];
		end
		if (rd.lac_re) begin
			rdata.letter_a <= lac_mem[rd.lac_addr_a];
			rdata.letter_b <= lac_mem[rd.lac_addr_b];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/pce_obuf.sv =====
// Output buffer holding one encrypted digraph and handing it out letter by letter.
`default_nettype none

module pce_obuf (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            load,
	input  wire pce_pkg::pair_t  pair,
	output logic                 empty,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output logic [6:0]           cipher_letter,
	output logic                 last
);

	pce_pkg::pair_t pair_q;
	logic [1:0]     cnt_q;
	logic [4:0]     sel;

	assign empty     = (cnt_q == 2'd0);
	assign out_valid = !empty;
	assign last      = (cnt_q == 2'd1);
	assign sel       = last ? pair_q.trail : pair_q.lead;

	assign cipher_letter = pce_pkg::ASCII_A + {2'b00, sel};

	always_ff @(posedge clk) begin
		if (load) begin
			pair_q <= pair;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load) begin
			cnt_q <= 2'd2;
		end else if (out_valid && out_ready) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/pce_ctrl.sv =====
// Sequencer: key placement, table completion walk, digraph forming and lookups.
`default_nettype none

module pce_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [1:0]           opcode,
	input  wire logic [7:0]           in_byte,
	output pce_pkg::tbl_wr_t          wr,
	output pce_pkg::tbl_rd_t          rd,
	input  wire pce_pkg::tbl_rdata_t  rdata,
	input  wire logic                 obuf_empty,
	output logic                      load,
	output pce_pkg::pair_t            pair
);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_FILL  = 5'b00010,
		S_TEXT  = 5'b00100,
		S_LOOK1 = 5'b01000,
		S_LOOK2 = 5'b10000
	} state_t;

	localparam logic [4:0] WALK_LAST = 5'(pce_pkg::LETTERS - 1);
	localparam logic [4:0] FULL      = 5'(pce_pkg::CELLS);

	function automatic logic [4:0] letter_of(input logic [7:0] b);
		logic [4:0] r;
		r = pce_pkg::NO_LETTER;
		if (b >= 8'h61 && b <= 8'h7a) begin
			r = 5'(b - 8'h61);
		end else if (b >= 8'h41 && b <= 8'h5a) begin
			r = 5'(b - 8'h41);
		end
		return r;
	endfunction

	function automatic logic [4:0] look_as(input logic [4:0] l);
		return (l == pce_pkg::IDX_J) ? pce_pkg::IDX_I : l;
	endfunction

	function automatic logic [2:0] row_of(input logic [4:0] c);
		logic [2:0] r;
		if (c >= 5'd20)      r = 3'd4;
		else if (c >= 5'd15) r = 3'd3;
		else if (c >= 5'd10) r = 3'd2;
		else if (c >= 5'd5)  r = 3'd1;
		else                 r = 3'd0;
		return r;
	endfunction

	function automatic logic [2:0] col_of(input logic [4:0] c);
		logic [2:0] r;
		r = row_of(c);
		return 3'(c - ({r, 2'b00} + 5'(r)));
	endfunction

	function automatic logic [4:0] cell_at(input logic [2:0] r, input logic [2:0] k);
		return {r, 2'b00} + 5'(r) + 5'(k);
	endfunction

	function automatic logic [2:0] inc5(input logic [2:0] x);
		return (x == 3'(pce_pkg::SIDE - 1)) ? 3'd0 : x + 3'd1;
	endfunction

	state_t            state_q, state_d;
	logic [25:0]       used_q, used_d;
	logic [4:0]        filled_q, filled_d;
	logic [4:0]        prev_q, prev_d;
	logic              prev_valid_q, prev_valid_d;
	logic [4:0]        pend_q, pend_d;
	logic              pend_valid_q, pend_valid_d;
	logic              key_phase_q, key_phase_d;
	logic [4:0]        walk_q, walk_d;
	pce_pkg::opcode_t  op_q, op_d;
	logic [4:0]        let_q, let_d;

	logic              acc;
	logic              full;
	pce_pkg::opcode_t  in_op;
	logic [4:0]        in_let;
	logic [4:0]        key_let;
	logic              fresh;
	logic [25:0]       used_base;
	logic [4:0]        filled_base;
	logic              key_place;
	logic              walk_place;

	pce_pkg::opcode_t  t_op;
	logic [4:0]        t_let;
	logic              step_en;
	logic              dbl;
	logic              go_pair;
	logic [4:0]        pa, pb;

	logic [2:0]        r1, r2, k1, k2;
	logic [4:0]        o1, o2;

	assign in_ready = (state_q == S_IDLE);
	assign acc      = in_valid && in_ready;
	assign full     = (filled_q == FULL);
	assign in_op    = pce_pkg::opcode_t'(opcode);
	assign in_let   = letter_of(in_byte);

	// Key byte: a key byte outside key phase opens a fresh table first.
	assign fresh       = !key_phase_q;
	assign used_base   = fresh ? '0 : used_q;
	assign filled_base = fresh ? 5'd0 : filled_q;
	assign key_let     = look_as(in_let);
	assign key_place   = (key_let != pce_pkg::NO_LETTER) && !used_base[key_let]
		&& (filled_base < FULL);

	assign walk_place = (walk_q != pce_pkg::IDX_J) && !used_q[walk_q] && (filled_q < FULL);

	// The digraph step works on the incoming item when the table is already
	// complete, otherwise on the latched item once the walk has finished.
	assign t_op    = (state_q == S_IDLE) ? in_op : op_q;
	assign t_let   = (state_q == S_IDLE) ? in_let : let_q;
	assign step_en = (state_q == S_TEXT)
		|| (acc && in_op != pce_pkg::OP_KEY_BYTE && full);
	assign dbl     = prev_valid_q && (prev_q == t_let);

	always_comb begin
		go_pair      = 1'b0;
		pa           = pend_q;
		pb           = pce_pkg::IDX_X;
		pend_d       = pend_q;
		pend_valid_d = pend_valid_q;
		prev_d       = prev_q;
		prev_valid_d = prev_valid_q;
		if (step_en) begin
			case (t_op)
				pce_pkg::OP_TEXT_BYTE: begin
					if (t_let != pce_pkg::NO_LETTER) begin
						prev_d       = t_let;
						prev_valid_d = 1'b1;
						if (dbl) begin
							go_pair = 1'b1;
							if (pend_valid_q) begin
								pend_d       = t_let;
								pend_valid_d = 1'b1;
							end else begin
								pa           = pce_pkg::IDX_X;
								pb           = t_let;
								pend_valid_d = 1'b0;
							end
						end else if (pend_valid_q) begin
							go_pair      = 1'b1;
							pb           = t_let;
							pend_valid_d = 1'b0;
						end else begin
							pend_d       = t_let;
							pend_valid_d = 1'b1;
						end
					end
				end
				pce_pkg::OP_TEXT_END: begin
					go_pair      = pend_valid_q;
					pend_valid_d = 1'b0;
					prev_valid_d = 1'b0;
				end
				default: begin
				end
			endcase
		end else if (acc && in_op == pce_pkg::OP_KEY_BYTE && fresh) begin
			pend_valid_d = 1'b0;
			prev_valid_d = 1'b0;
		end
	end

	// Playfair rules on the two cells returned by the first lookup.
	always_comb begin
		r1 = row_of(rdata.cell_a);
		r2 = row_of(rdata.cell_b);
		k1 = col_of(rdata.cell_a);
		k2 = col_of(rdata.cell_b);
		if (r1 == r2) begin
			o1 = cell_at(r1, inc5(k1));
			o2 = cell_at(r2, inc5(k2));
		end else if (k1 == k2) begin
			o1 = cell_at(inc5(r1), k1);
			o2 = cell_at(inc5(r2), k2);
		end else begin
			o1 = cell_at(r1, k2);
			o2 = cell_at(r2, k1);
		end
	end

	// Only key bytes and the walk write; reads come from text transactions once the
	// square is complete and never in a writing cycle, so no forwarding is needed.
	always_comb begin
		wr.we     = 1'b0;
		wr.slot   = filled_base;
		wr.letter = key_let;
		if (state_q == S_FILL) begin
			wr.we     = walk_place;
			wr.slot   = filled_q;
			wr.letter = walk_q;
		end else if (acc && in_op == pce_pkg::OP_KEY_BYTE) begin
			wr.we = key_place;
		end
	end

	assign rd.cof_re     = go_pair;
	assign rd.cof_addr_a = look_as(pa);
	assign rd.cof_addr_b = look_as(pb);
	assign rd.lac_re     = (state_q == S_LOOK1);
	assign rd.lac_addr_a = o1;
	assign rd.lac_addr_b = o2;

	assign load       = (state_q == S_LOOK2) && obuf_empty;
	assign pair.lead  = rdata.letter_a;
	assign pair.trail = rdata.letter_b;

	always_comb begin
		state_d     = state_q;
		used_d      = used_q;
		filled_d    = filled_q;
		key_phase_d = key_phase_q;
		walk_d      = walk_q;
		op_d        = op_q;
		let_d       = let_q;
		unique case (state_q)
			S_IDLE: begin
				if (acc) begin
					if (in_op == pce_pkg::OP_KEY_BYTE) begin
						key_phase_d = 1'b1;
						used_d      = used_base | (key_place ? (26'd1 << key_let) : 26'd0);
						filled_d    = filled_base + 5'(key_place);
					end else begin
						key_phase_d = 1'b0;
						op_d        = in_op;
						let_d       = in_let;
						if (!full) begin
							walk_d  = 5'd0;
							state_d = S_FILL;
						end else if (go_pair) begin
							state_d = S_LOOK1;
						end
					end
				end
			end
			S_FILL: begin
				if (walk_place) begin
					used_d   = used_q | (26'd1 << walk_q);
					filled_d = filled_q + 5'd1;
				end
				walk_d = walk_q + 5'd1;
				if (walk_q == WALK_LAST) begin
					state_d = (op_q == pce_pkg::OP_KEY_END) ? S_IDLE : S_TEXT;
				end
			end
			S_TEXT: begin
				state_d = go_pair ? S_LOOK1 : S_IDLE;
			end
			S_LOOK1: begin
				state_d = S_LOOK2;
			end
			S_LOOK2: begin
				if (obuf_empty) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		walk_q <= walk_d;
		op_q   <= op_d;
		let_q  <= let_d;
		prev_q <= prev_d;
		pend_q <= pend_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			used_q       <= '0;
			filled_q     <= 5'd0;
			prev_valid_q <= 1'b0;
			pend_valid_q <= 1'b0;
			key_phase_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			used_q       <= used_d;
			filled_q     <= filled_d;
			prev_valid_q <= prev_valid_d;
			pend_valid_q <= pend_valid_d;
			key_phase_q  <= key_phase_d;
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		filled_q <= FULL)
		else $error("key square fill count beyond the square");

	a_used_matches_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(used_q) == filled_q)
		else $error("used letters disagree with the fill count");

	a_no_j_placed: assert property (@(posedge clk) disable iff (!arst_n)
		!used_q[pce_pkg::IDX_J])
		else $error("letter J placed in the key square");

	a_walk_completes: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FILL && walk_q == WALK_LAST) |=> full)
		else $error("completion walk left the key square short");

	a_lookup_needs_full: assert property (@(posedge clk) disable iff (!arst_n)
		rd.cof_re |-> full)
		else $error("lookup issued before the key square was complete");

endmodule

`default_nettype wire

// ===== rtl/core/playfair_cipher_encrypt.sv =====
// Top level of the Playfair encryptor: sequencer, key square memories and output buffer.
//
//  Channel  Direction  Handshake            Payload
//  input    in         in_valid / in_ready  opcode[1:0], in_byte[7:0]
//  output   out        out_valid/out_ready  cipher_letter[6:0], last
//
// A key byte, a key end on a complete square and a text transaction that forms no digraph
// keep the sequencer idle; a digraph takes two memory reads in turn, then the load.
// On an incomplete square a key end adds a walk over all letters that fills the empty cells;
// a text transaction adds that walk and then resumes its digraph step in S_TEXT.
// Reset clears only control state; the memories are read only once the square is complete.
// Output drains under later transactions; a new digraph stalls input until the buffer empties.
`default_nettype none

module playfair_cipher_encrypt (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  opcode,
	input  wire logic [7:0]  in_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [6:0]       cipher_letter,
	output logic             last
);

	pce_pkg::tbl_wr_t    wr;
	pce_pkg::tbl_rd_t    rd;
	pce_pkg::tbl_rdata_t rdata;
	pce_pkg::pair_t      pair;
	logic                load;
	logic                obuf_empty;

	pce_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.opcode     (opcode),
		.in_byte    (in_byte),
		.wr         (wr),
		.rd         (rd),
		.rdata      (rdata),
		.obuf_empty (obuf_empty),
		.load       (load),
		.pair       (pair)
	);

	pce_table u_table (
		.clk   (clk),
		.wr    (wr),
		.rd    (rd),
		.rdata (rdata)
	);

	pce_obuf u_obuf (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (load),
		.pair          (pair),
		.empty         (obuf_empty),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.cipher_letter (cipher_letter),
		.last          (last)
	);

endmodule

`default_nettype wire

// ===== sim/playfair_cipher_encrypt_test.sv =====
// Self-checking testbench of the Playfair encryptor, with its own model of the key square.
`timescale 1ns / 100ps

module playfair_cipher_encrypt_test;
	import pce_pkg::*;

	localparam int unsigned STALL_LIMIT  = 2000;
	localparam int unsigned PHASE_ITEMS  = 500;
	localparam int unsigned DRAIN_CYCLES = 40;
	localparam logic [7:0]  LOWER_A      = 8'h61;
	localparam logic [7:0]  LOWER_Z      = 8'h7A;
	localparam logic [7:0]  UPPER_A      = 8'h41;
	localparam logic [7:0]  UPPER_Z      = 8'h5A;
	localparam logic [7:0]  CASE_BIT     = 8'h20;

	typedef struct packed {
		logic [6:0] letter;
		logic       last;
	} cipher_out_t;

	typedef struct {
		opcode_t     op;
		logic [7:0]  data;
		bit          typed;
		int unsigned n;
		logic [6:0]  c0;
		logic [6:0]  c1;
	} stim_row_t;

	logic       clk;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [1:0] opcode = OP_KEY_BYTE;
	logic [7:0] in_byte = 8'h00;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [6:0] cipher_letter;
	logic       last;

	// Key square as the predictor sees it.
	logic [LET_W-1:0]  sq_letter [CELLS];
	logic [CELL_W-1:0] sq_cell [LETTERS];
	bit                used [LETTERS];
	int unsigned       filled = 0;
	logic [LET_W-1:0]  prev_letter = '0;
	bit                prev_ok = 1'b0;
	logic [LET_W-1:0]  held_letter = '0;
	bit                held_ok = 1'b0;
	bit                keying = 1'b0;

	cipher_out_t step_out[$];
	cipher_out_t cipher_due[$];
	stim_row_t   directed_rows[25];

	int unsigned src_idle_pct = 0;
	int unsigned dst_idle_pct = 0;
	int unsigned live_items = 0;
	int unsigned messages = 0;
	int unsigned letters_checked = 0;
	int unsigned mismatches = 0;

	playfair_cipher_encrypt DUT (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		foreach (sq_letter[i]) sq_letter[i] = '0;
		foreach (sq_cell[i]) sq_cell[i] = '0;
		foreach (used[i]) used[i] = 1'b0;
	end

	function automatic logic [LET_W-1:0] letter_of(logic [7:0] b);
		if (b >= LOWER_A && b <= LOWER_Z) return LET_W'(b - LOWER_A);
		if (b >= UPPER_A && b <= UPPER_Z) return LET_W'(b - UPPER_A);
		return NO_LETTER;
	endfunction

	function automatic void place(logic [LET_W-1:0] l);
		if (l >= LETTERS || l == IDX_J || used[l] || filled >= CELLS) return;
		sq_letter[filled] = l;
		sq_cell[l] = CELL_W'(filled);
		used[l] = 1'b1;
		filled++;
	endfunction

	function automatic void fill_square();
		for (int i = 0; i < LETTERS; i++) place(LET_W'(i));
		keying = 1'b0;
	endfunction

	function automatic int unsigned cell_for(logic [LET_W-1:0] l);
		return int'(sq_cell[(l == IDX_J) ? IDX_I : l]);
	endfunction

	function automatic void add_letter(logic [LET_W-1:0] l);
		int unsigned c1, c2, r1, r2, k1, k2, o1, o2;
		if (!held_ok) begin
			held_letter = l;
			held_ok = 1'b1;
			return;
		end
		held_ok = 1'b0;
		c1 = cell_for(held_letter);
		c2 = cell_for(l);
		r1 = c1 / SIDE;
		k1 = c1 % SIDE;
		r2 = c2 / SIDE;
		k2 = c2 % SIDE;
		if (r1 == r2) begin
			o1 = r1 * SIDE + (k1 + 1) % SIDE;
			o2 = r2 * SIDE + (k2 + 1) % SIDE;
		end else if (k1 == k2) begin
			o1 = ((r1 + 1) % SIDE) * SIDE + k1;
			o2 = ((r2 + 1) % SIDE) * SIDE + k2;
		end else begin
			o1 = r1 * SIDE + k2;
			o2 = r2 * SIDE + k1;
		end
		step_out.push_back(cipher_out_t'{ASCII_A + 7'(sq_letter[o1]), 1'b0});
		step_out.push_back(cipher_out_t'{ASCII_A + 7'(sq_letter[o2]), 1'b1});
	endfunction

	// Updates the square and the digraph state for one transaction; results go to step_out.
	function automatic void encipher_item(opcode_t op, logic [7:0] b);
		logic [LET_W-1:0] l;
		l = letter_of(b);
		step_out.delete();
		case (op)
			OP_KEY_BYTE: begin
				if (!keying) begin
					foreach (used[i]) used[i] = 1'b0;
					filled = 0;
					held_ok = 1'b0;
					prev_ok = 1'b0;
					keying = 1'b1;
				end
				place((l == IDX_J) ? IDX_I : l);
			end
			OP_KEY_END: begin
				fill_square();
			end
			OP_TEXT_BYTE: begin
				fill_square();
				if (l != NO_LETTER) begin
					if (prev_ok && prev_letter == l) add_letter(IDX_X);
					add_letter(l);
					prev_letter = l;
					prev_ok = 1'b1;
				end
			end
			default: begin
				fill_square();
				if (held_ok) add_letter(IDX_X);
				prev_ok = 1'b0;
			end
		endcase
	endfunction

	function automatic logic [7:0] letter_byte();
		logic [7:0] b;
		b = UPPER_A + 8'($urandom_range(25));
		if ($urandom_range(1) == 1) b = b | CASE_BIT;
		return b;
	endfunction

	function automatic logic [7:0] any_byte();
		return 8'($urandom_range(255));
	endfunction

	// Presents one transaction and returns at the edge where it is taken.
	task automatic offer(opcode_t op, logic [7:0] b);
		if ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
		end
		in_valid <= 1'b1;
		opcode <= op;
		in_byte <= b;
		do @(posedge clk); while (!in_ready);
		if (!((op == OP_KEY_BYTE || op == OP_TEXT_BYTE) && letter_of(b) == NO_LETTER))
			live_items++;
	endtask

	task automatic send_item(opcode_t op, logic [7:0] b);
		offer(op, b);
		encipher_item(op, b);
		foreach (step_out[i]) cipher_due.push_back(step_out[i]);
	endtask

	// Mostly a key, a key end and a short text; now and then a burst of arbitrary transactions.
	task automatic send_message();
		int unsigned n;
		logic [7:0] b, prev_b;
		messages++;
		if ($urandom_range(9) == 0) begin
			n = $urandom_range(8, 1);
			repeat (n) send_item(opcode_t'(2'($urandom_range(3))), any_byte());
			return;
		end
		if ($urandom_range(7) != 0) begin
			n = $urandom_range(12);
			repeat (n) send_item(OP_KEY_BYTE,
				($urandom_range(6) == 0) ? any_byte() : letter_byte());
			if ($urandom_range(7) != 0) send_item(OP_KEY_END, any_byte());
		end
		prev_b = letter_byte();
		n = $urandom_range(16, 1);
		repeat (n) begin
			case ($urandom_range(9))
				0: b = any_byte();
				1, 2: b = prev_b ^ (8'($urandom_range(1)) << 5);
				default: b = letter_byte();
			endcase
			send_item(OP_TEXT_BYTE, b);
			prev_b = b;
		end
		if ($urandom_range(5) != 0) send_item(OP_TEXT_END, any_byte());
	endtask

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= dst_idle_pct);
	end

	always @(posedge clk) begin
		cipher_out_t want;
		if (arst_n && out_valid && out_ready) begin
			letters_checked++;
			if (cipher_due.size() == 0) begin
				mismatches++;
				$display("%0t: cipher letter %h (last %b) arrived with none expected",
					$time, cipher_letter, last);
			end else begin
				want = cipher_due.pop_front();
				if (cipher_letter !== want.letter) begin
					mismatches++;
					$display("%0t: cipher_letter expected %h, got %h",
						$time, want.letter, cipher_letter);
				end
				if (last !== want.last) begin
					mismatches++;
					$display("%0t: last expected %b, got %b", $time, want.last, last);
				end
			end
		end
	end

	initial begin
		int unsigned stall_cycles;
		stall_cycles = 0;
		while (stall_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
			else stall_cycles++;
		end
		$display("No transaction for %0d cycles, %0d letters still expected",
			STALL_LIMIT, cipher_due.size());
		$display("Verification failed");
		$finish;
	end

	initial begin
		int unsigned phase_end;
		// After reset the square fills in alphabetical order, so the first rows are easy to
		// work out by hand; the later rows build a keyed square and rely on the predictor.
		directed_rows = '{
			'{OP_TEXT_END,  8'h00, 1'b1, 0, 7'h00, 7'h00},
			'{OP_TEXT_BYTE, 8'h61, 1'b1, 0, 7'h00, 7'h00},
			'{OP_TEXT_BYTE, 8'h42, 1'b1, 2, 7'h42, 7'h43},
			'{OP_TEXT_BYTE, 8'h7A, 1'b1, 0, 7'h00, 7'h00},
			'{OP_TEXT_BYTE, 8'h5A, 1'b1, 2, 7'h56, 7'h59},
			'{OP_TEXT_END,  8'hFF, 1'b1, 2, 7'h56, 7'h59},
			'{OP_TEXT_BYTE, 8'hFF, 1'b1, 0, 7'h00, 7'h00},
			'{OP_TEXT_BYTE, 8'h40, 1'b1, 0, 7'h00, 7'h00},
			'{OP_TEXT_BYTE, 8'h5B, 1'b1, 0, 7'h00, 7'h00},
			'{OP_TEXT_BYTE, 8'h60, 1'b1, 0, 7'h00, 7'h00},
			'{OP_TEXT_BYTE, 8'h7B, 1'b1, 0, 7'h00, 7'h00},
			'{OP_TEXT_BYTE, 8'h58, 1'b1, 0, 7'h00, 7'h00},
			'{OP_TEXT_END,  8'h00, 1'b1, 2, 7'h59, 7'h59},
			'{OP_TEXT_BYTE, 8'h41, 1'b0, 0, 7'h00, 7'h00},
			'{OP_KEY_BYTE,  8'h70, 1'b0, 0, 7'h00, 7'h00},
			'{OP_KEY_BYTE,  8'h4A, 1'b0, 0, 7'h00, 7'h00},
			'{OP_KEY_BYTE,  8'h20, 1'b0, 0, 7'h00, 7'h00},
			'{OP_KEY_BYTE,  8'h80, 1'b0, 0, 7'h00, 7'h00},
			'{OP_KEY_BYTE,  8'h70, 1'b0, 0, 7'h00, 7'h00},
			'{OP_KEY_BYTE,  8'h4C, 1'b0, 0, 7'h00, 7'h00},
			'{OP_TEXT_BYTE, 8'h6A, 1'b0, 0, 7'h00, 7'h00},
			'{OP_TEXT_BYTE, 8'h41, 1'b0, 0, 7'h00, 7'h00},
			'{OP_TEXT_BYTE, 8'h49, 1'b0, 0, 7'h00, 7'h00},
			'{OP_KEY_END,   8'hFF, 1'b0, 0, 7'h00, 7'h00},
			'{OP_TEXT_END,  8'h00, 1'b0, 0, 7'h00, 7'h00}
		};
		src_idle_pct = 9;
		dst_idle_pct = 77;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			offer(directed_rows[i].op, directed_rows[i].data);
			encipher_item(directed_rows[i].op, directed_rows[i].data);
			if (!directed_rows[i].typed) begin
				foreach (step_out[j]) cipher_due.push_back(step_out[j]);
			end else if (directed_rows[i].n == 2) begin
				cipher_due.push_back(cipher_out_t'{directed_rows[i].c0, 1'b0});
				cipher_due.push_back(cipher_out_t'{directed_rows[i].c1, 1'b1});
			end
		end

		for (int p = 0; p < 3; p++) begin
			case (p)
				0: begin
					src_idle_pct = 9;
					dst_idle_pct = 77;
				end
				1: begin
					src_idle_pct = 77;
					dst_idle_pct = 9;
				end
				default: begin
					src_idle_pct = 0;
					dst_idle_pct = 0;
				end
			endcase
			phase_end = live_items + PHASE_ITEMS;
			while (live_items < phase_end) send_message();
			// Hold the input back until every outstanding letter has drained.
			in_valid <= 1'b0;
			do @(posedge clk); while (cipher_due.size() != 0);
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Run covered %0d transactions in %0d random messages plus the directed table.",
			live_items, messages);
		$display("%0d cipher letters were checked, %0d mismatches.", letters_checked, mismatches);
		if (mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
